@@ design/qph_pkg.sv @@
// Shared types and constants of the quadratic probe hash table.
package qph_pkg;

    localparam int KEY_W  = 31;
    localparam int VAL_W  = 32;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 3;
    localparam int SLOT_W = 4;

    // Stream payload layout, lowest field first.
    localparam int IN_DATA_W  = 72;
    localparam int CMD_LSB    = 0;
    localparam int KEY_LSB    = CMD_LSB + CMD_W;
    localparam int VAL_LSB    = KEY_LSB + KEY_W;

    localparam int OUT_DATA_W = 40;
    localparam int OUT_PAD_W  = OUT_DATA_W - STAT_W - VAL_W - SLOT_W;
    localparam int STAT_LSB   = 0;
    localparam int FVAL_LSB   = STAT_LSB + STAT_W;
    localparam int SLOT_LSB   = FVAL_LSB + VAL_W;

    localparam int KEY_CNT_W = $clog2(KEY_W);

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_DELETE = 2'd2
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        STAT_INSERTED  = 3'd0,
        STAT_FULL      = 3'd1,
        STAT_FOUND     = 3'd2,
        STAT_NOT_FOUND = 3'd3,
        STAT_DELETED   = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HOME,
        S_PROBE,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic        [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } t_entry;

endpackage

@@ design/quadratic_probe_hash_table_unit.sv @@
// Flow: an accepted item gets its home slot (the low key bits for a power-of-two size,
// reciprocal multiplication otherwise), probes up to TABLE_SIZE slots, then goes to the output.
// An unused command code skips the probe and returns NOT_FOUND; the probe loop
// reads one slot per cycle through the single read port of the slot memory.
// One item is in flight at a time. After reset the used bits of all slots are cleared
// before the first transfer is accepted; reset is synchronous and active low.
module quadratic_probe_hash_table_unit #(
    parameter int TABLE_SIZE = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // command [1:0], key [32:2], value [64:33], zero [71:65]
    input  logic [qph_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // status [2:0], found_value [34:3], slot_index [38:35], zero [39]
    output logic [qph_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import qph_pkg::*;

    localparam int IW = $clog2(TABLE_SIZE);
    localparam int LW = $clog2(TABLE_SIZE + 1);
    localparam logic [IW-1:0] LAST_SLOT = IW'(TABLE_SIZE - 1);
    localparam logic [IW-1:0] SQ0       = IW'(1);
    localparam logic [IW-1:0] INC0      = IW'(3 % TABLE_SIZE);

    t_state r_state, n_state;

    logic [IW-1:0]     r_clr_addr;
    logic [CMD_W-1:0]  r_cmd;
    logic [KEY_W-1:0]  r_key;
    logic signed [VAL_W-1:0] r_val;
    logic [IW-1:0]     r_idx, r_sq, r_inc;
    logic [LW-1:0]     r_left;
    logic              r_chk_valid;
    logic [IW-1:0]     r_chk_idx;
    t_status           r_status;
    logic [IW-1:0]     r_slot;
    logic signed [VAL_W-1:0] r_fval;

    logic              r_out_valid;
    t_status           r_out_status;
    logic signed [VAL_W-1:0] r_out_fval;
    logic [SLOT_W-1:0] r_out_slot;

    logic [CMD_W-1:0]  in_cmd;
    logic [KEY_W-1:0]  in_key;
    logic signed [VAL_W-1:0] in_val;
    logic              in_known;
    logic              in_accept;

    logic              km_start, km_done;
    logic [IW-1:0]     km_rem;
    logic [IW-1:0]     step_idx, step_sq, step_inc;

    logic              we_entry, we_used, wused;
    logic [IW-1:0]     waddr;
    t_entry            wentry;
    t_entry            rd_entry;
    logic              rd_used;

    logic              hit_free, hit_key, p_stop, p_found, p_exhaust, p_end;
    t_status           p_status;
    logic              out_free, fin_load;

    assign in_cmd    = s_axis_tdata[CMD_LSB +: CMD_W];
    assign in_key    = s_axis_tdata[KEY_LSB +: KEY_W];
    assign in_val    = s_axis_tdata[VAL_LSB +: VAL_W];
    assign in_known  = (in_cmd == CMD_INSERT) || (in_cmd == CMD_SEARCH) ||
                       (in_cmd == CMD_DELETE);
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_free  = !r_out_valid || m_axis_tready;

    assign wentry.key   = r_key;
    assign wentry.value = r_val;

    qph_keymod #(.TABLE_SIZE(TABLE_SIZE)) u_keymod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (km_start),
        .i_key   (in_key),
        .o_done  (km_done),
        .o_rem   (km_rem)
    );

    qph_probe_step #(.TABLE_SIZE(TABLE_SIZE)) u_step (
        .i_idx (r_idx),
        .i_sq  (r_sq),
        .i_inc (r_inc),
        .o_idx (step_idx),
        .o_sq  (step_sq),
        .o_inc (step_inc)
    );

    qph_store #(.TABLE_SIZE(TABLE_SIZE)) u_store (
        .i_clk      (i_clk),
        .i_we_entry (we_entry),
        .i_we_used  (we_used),
        .i_waddr    (waddr),
        .i_wentry   (wentry),
        .i_wused    (wused),
        .i_raddr    (r_idx),
        .o_rentry   (rd_entry),
        .o_rused    (rd_used)
    );

    // The slot checked this cycle is the one whose read was issued last cycle.
    always_comb begin
        hit_free  = r_chk_valid && !rd_used;
        hit_key   = r_chk_valid && rd_used && (rd_entry.key == r_key);
        p_stop    = (r_cmd == CMD_INSERT) ? hit_free : (hit_free || hit_key);
        p_found   = (r_cmd == CMD_INSERT) ? hit_free : hit_key;
        p_exhaust = r_chk_valid && !p_stop && (r_left == '0);
        p_end     = p_stop || p_exhaust;
        priority if (r_cmd == CMD_INSERT) begin
            p_status = p_found ? STAT_INSERTED : STAT_FULL;
        end else if (r_cmd == CMD_SEARCH) begin
            p_status = p_found ? STAT_FOUND : STAT_NOT_FOUND;
        end else begin
            p_status = p_found ? STAT_DELETED : STAT_NOT_FOUND;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == LAST_SLOT) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = in_known ? S_HOME : S_FINISH;
                end
            end
            S_HOME: begin
                if (km_done) begin
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                if (p_end) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        km_start      = 1'b0;
        we_entry      = 1'b0;
        we_used       = 1'b0;
        wused         = 1'b0;
        waddr         = r_slot;
        fin_load      = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                we_used = 1'b1;
                waddr   = r_clr_addr;
            end
            S_IDLE: begin
                s_axis_tready = 1'b1;
                km_start      = s_axis_tvalid && in_known;
            end
            S_HOME, S_PROBE: begin
            end
            S_FINISH: begin
                fin_load = out_free;
                we_entry = out_free && (r_status == STAT_INSERTED);
                we_used  = out_free && ((r_status == STAT_INSERTED) ||
                                        (r_status == STAT_DELETED));
                wused    = (r_status == STAT_INSERTED);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_chk_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (r_state == S_PROBE && !p_end) begin
                r_chk_valid <= (r_left != '0);
            end else begin
                r_chk_valid <= 1'b0;
            end
            if (fin_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd    <= in_cmd;
            r_key    <= in_key;
            r_val    <= in_val;
            r_status <= STAT_NOT_FOUND;
            r_slot   <= '0;
            r_fval   <= '0;
        end
        if (r_state == S_HOME && km_done) begin
            r_idx  <= km_rem;
            r_sq   <= SQ0;
            r_inc  <= INC0;
            r_left <= LW'(TABLE_SIZE);
        end
        if (r_state == S_PROBE) begin
            if (p_end) begin
                r_status <= p_status;
                r_slot   <= p_found ? r_chk_idx : '0;
                r_fval   <= (p_found && r_cmd == CMD_SEARCH) ? rd_entry.value : '0;
            end else if (r_left != '0) begin
                r_chk_idx <= r_idx;
                r_idx     <= step_idx;
                r_sq      <= step_sq;
                r_inc     <= step_inc;
                r_left    <= r_left - 1'b1;
            end
        end
        if (fin_load) begin
            r_out_status <= r_status;
            r_out_fval   <= r_fval;
            r_out_slot   <= SLOT_W'(r_slot);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_out_slot, r_out_fval, r_out_status};

endmodule

@@ design/qph_keymod.sv @@
// Reduction of a key modulo the table size: the low key bits for a power-of-two size, else reciprocal multiplication.
module qph_keymod #(
    parameter int TABLE_SIZE = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [qph_pkg::KEY_W-1:0] i_key,
    output logic                      o_done,
    output logic [$clog2(TABLE_SIZE)-1:0] o_rem
);
    import qph_pkg::*;

    localparam int IW = $clog2(TABLE_SIZE);
    localparam int QW = 32 - IW;
    localparam logic [IW:0]      NS = (IW+1)'(TABLE_SIZE);
    localparam logic [KEY_W-1:0] NK = KEY_W'(TABLE_SIZE);
    localparam bit POW2 = ((TABLE_SIZE & (TABLE_SIZE - 1)) == 0);
    // The reciprocal 2^(KEY_W+IW) / TABLE_SIZE always fits in 32 bits.
    localparam logic [63:0] RECIP_FULL = (64'd1 << (KEY_W + IW)) / 64'(TABLE_SIZE);
    localparam logic [31:0] RECIP      = RECIP_FULL[31:0];

    logic                 r_s1;
    logic                 r_s2;
    logic                 r_s3;
    logic                 r_done;
    logic [KEY_W-1:0]     r_key;
    logic [QW-1:0]        r_quo;
    logic [IW:0]          r_diff;
    logic [IW-1:0]        r_rem;
    logic [KEY_W+31:0]    prod;
    logic [KEY_W-1:0]     diff;
    logic [IW:0]          fix;
    logic [IW-1:0]        n_rem;

    // The estimated quotient is low by at most one, so one compare and subtract finishes.
    always_comb begin
        prod  = {32'd0, r_key} * {{KEY_W{1'b0}}, RECIP};
        diff  = r_key - KEY_W'(r_quo) * NK;
        fix   = (r_diff >= NS) ? (r_diff - NS) : r_diff;
        n_rem = fix[IW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1   <= 1'b0;
            r_s2   <= 1'b0;
            r_s3   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_s1   <= i_start && !POW2;
            r_s2   <= r_s1;
            r_s3   <= r_s2;
            r_done <= (i_start && POW2) || r_s3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_key <= i_key;
        end
        if (r_s1) begin
            r_quo <= prod[KEY_W+IW +: QW];
        end
        if (r_s2) begin
            r_diff <= diff[IW:0];
        end
        if (i_start && POW2) begin
            r_rem <= i_key[IW-1:0];
        end else if (r_s3) begin
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

@@ design/qph_probe_step.sv @@
// Probe step unit: advances slot index, square offset and its increment modulo the size.
module qph_probe_step #(
    parameter int TABLE_SIZE = 16
) (
    input  logic [$clog2(TABLE_SIZE)-1:0] i_idx,
    input  logic [$clog2(TABLE_SIZE)-1:0] i_sq,
    input  logic [$clog2(TABLE_SIZE)-1:0] i_inc,
    output logic [$clog2(TABLE_SIZE)-1:0] o_idx,
    output logic [$clog2(TABLE_SIZE)-1:0] o_sq,
    output logic [$clog2(TABLE_SIZE)-1:0] o_inc
);
    import qph_pkg::*;

    localparam int IW = $clog2(TABLE_SIZE);
    localparam logic [IW:0]   NS  = (IW+1)'(TABLE_SIZE);
    localparam logic [IW-1:0] TWO = IW'(2 % TABLE_SIZE);

    function automatic logic [IW-1:0] mod_add(input logic [IW-1:0] a, input logic [IW-1:0] b);
        logic [IW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= NS) begin
            s = s - NS;
        end
        return s[IW-1:0];
    endfunction

    // (i+1)^2 = i^2 + (2i+1), so both offsets advance by additions only.
    assign o_idx = mod_add(i_idx, i_sq);
    assign o_sq  = mod_add(i_sq, i_inc);
    assign o_inc = mod_add(i_inc, TWO);

endmodule

@@ design/qph_store.sv @@
// Slot memories: key/value entries and the per-slot used bits, registered reads.
module qph_store #(
    parameter int TABLE_SIZE = 16
) (
    input  logic                          i_clk,
    input  logic                          i_we_entry,
    input  logic                          i_we_used,
    input  logic [$clog2(TABLE_SIZE)-1:0] i_waddr,
    input  qph_pkg::t_entry               i_wentry,
    input  logic                          i_wused,
    input  logic [$clog2(TABLE_SIZE)-1:0] i_raddr,
    output qph_pkg::t_entry               o_rentry,
    output logic                          o_rused
);
    import qph_pkg::*;

    t_entry r_entry_mem [TABLE_SIZE];
    logic   r_used_mem  [TABLE_SIZE];
    t_entry r_rd_entry;
    logic   r_rd_used;

    always_ff @(posedge i_clk) begin
        if (i_we_entry) begin
            r_entry_mem[i_waddr] <= i_wentry;
        end
        r_rd_entry <= r_entry_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_we_used) begin
            r_used_mem[i_waddr] <= i_wused;
        end
        r_rd_used <= r_used_mem[i_raddr];
    end

    assign o_rentry = r_rd_entry;
    assign o_rused  = r_rd_used;

endmodule

@@ design/qph_checker.sv @@
// Port-level checks of the hash table unit and their binding to the top level.
module qph_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_m_axis_tvalid,
    input logic                           i_m_axis_tready,
    input logic [qph_pkg::OUT_DATA_W-1:0] i_m_axis_tdata
);
    import qph_pkg::*;

    logic [STAT_W-1:0] status;
    logic [VAL_W-1:0]  fval;
    logic [SLOT_W-1:0] slot;

    assign status = i_m_axis_tdata[STAT_LSB +: STAT_W];
    assign fval   = i_m_axis_tdata[FVAL_LSB +: VAL_W];
    assign slot   = i_m_axis_tdata[SLOT_LSB +: SLOT_W];

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_axis_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && !i_m_axis_tready |=> i_m_axis_tvalid && $stable(i_m_axis_tdata))
        else $error("stalled result changed");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid |-> status <= STAT_DELETED)
        else $error("status code out of range");

    a_value_only_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && status != STAT_FOUND |-> fval == '0)
        else $error("found_value set without a hit");

    a_slot_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && (status == STAT_FULL || status == STAT_NOT_FOUND) |-> slot == '0)
        else $error("slot_index set on a miss");

endmodule

bind quadratic_probe_hash_table_unit qph_checker u_qph_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_m_axis_tvalid (m_axis_tvalid),
    .i_m_axis_tready (m_axis_tready),
    .i_m_axis_tdata  (m_axis_tdata)
);
